FILE: src/bldq_pkg.sv
// Shared constants for the bounded list deque: beat layouts, field widths,
// operation and status codes, and parameter defaults.
// No dependencies.
package bldq_pkg;

  // Field widths on the ports
  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;

  // Beat layouts, padded to whole bytes
  localparam int S_TDATA_W = 40;   // mode, value
  localparam int M_TDATA_W = 104;  // status, popped_value, entry_count, first_value, last_value

  // Parameter defaults
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes
  localparam logic [MODE_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [MODE_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] OP_REMOVE     = 3'd2;
  localparam logic [MODE_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [MODE_W-1:0] OP_POP_BACK   = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

endpackage

FILE: src/bounded_list_deque_with_match_remove.sv
// Bounded deque of data words kept in a circular on-chip memory, with
// push/pop at both ends and remove-first-match. Depends on bldq_pkg.
//
// Usage:
//   s_* : operation beats. tdata from bit 0 up: mode[2:0], value[31:0].
//   m_* : one result beat per operation. tdata from bit 0 up: status[1:0],
//         popped_value[31:0], entry_count[4:0], first_value[31:0],
//         last_value[31:0].
//   cfg_* : writes capacity_limit; always ready. Write only while idle.
// Push, refused ops and unknown modes go from IDLE through RDF, RDL and OUT;
//   pops add POP; remove adds a SCAN step per entry scanned and a SHIFT
//   step per entry moved up, as scan and move visit each entry once. All
//   words live in one memory with a registered read; the front and
//   back words are read back from it before each result.
// One operation is in flight at a time; s_tready is high only when idle,
// so a new operation is not accepted until the last one's result is loaded.
// A result waiting on m_tready sits in the output register while the next
// operation is accepted and worked; that one finishes once the slot frees.
// Reset (rst, synchronous) empties the list, sets capacity_limit to 16 and
// drops any pending result. Memory contents are not cleared.
module bounded_list_deque_with_match_remove
  import bldq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // mode[2:0], value[34:3]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // status, popped_value, entry_count, first, last
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CAP_W-1:0]     cfg_data   // capacity_limit
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = PW + 2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_POP   = 7'b0001000,
    S_RDF   = 7'b0010000,
    S_RDL   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                            input logic [CW-1:0] p);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(p);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[PW-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] to_val(input logic [DATA_WIDTH-1:0] d);
    logic [63:0] w;
    w = 64'(d);
    return w[VALUE_W-1:0];
  endfunction

  state_t                state, state_next;
  logic [PW-1:0]         fp;
  logic [CW-1:0]         count;
  logic [CW-1:0]         pos;
  logic [CAP_W-1:0]      cap;
  logic [MODE_W-1:0]     mode_r;
  logic [DATA_WIDTH-1:0] word_r;
  logic [STATUS_W-1:0]   status_r;
  logic [DATA_WIDTH-1:0] popped_r;
  logic [DATA_WIDTH-1:0] first_r;
  logic                  out_valid;
  logic [M_TDATA_W-1:0]  out_data;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata;
  logic                  we;
  logic [PW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [PW-1:0]         raddr;
  logic [CW-1:0]         rd_pos;

  logic                  s_accept;
  logic [MODE_W-1:0]     in_mode;
  logic [VALUE_W-1:0]    in_value;
  logic [63:0]           value64;
  logic [DATA_WIDTH-1:0] word_in;
  logic                  full;
  logic [PW-1:0]         fp_dec;
  logic [PW-1:0]         fp_inc;
  logic                  out_load;
  logic [31:0]           count32;
  logic                  is_empty;

  assign s_tready  = (state == S_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  assign in_mode  = s_tdata[MODE_W-1:0];
  assign in_value = s_tdata[MODE_W +: VALUE_W];
  assign value64  = 64'(in_value);
  assign word_in  = value64[DATA_WIDTH-1:0];

  // Effective limit is capacity_limit saturated to DEPTH
  assign full   = (count >= CW'(DEPTH)) || (32'(count) >= 32'(cap));
  assign fp_dec = (fp == '0) ? PW'(DEPTH - 1) : fp - PW'(1);
  assign fp_inc = (32'(fp) == DEPTH - 1) ? '0 : fp + PW'(1);

  assign out_load = (state == S_OUT) && (!out_valid || m_tready);
  assign count32  = 32'(count);
  assign is_empty = (count == '0);

  // Read address for the data needed in the following cycle
  always_comb begin
    rd_pos = '0;
    case (state)
      S_IDLE:  rd_pos = (in_mode == OP_POP_BACK) ? count - CW'(1) : '0;
      S_SCAN:  rd_pos = pos + CW'(1);
      S_SHIFT: rd_pos = pos + CW'(2);
      S_RDL,
      S_OUT:   rd_pos = count - CW'(1);
      default: rd_pos = '0;
    endcase
    raddr = slot_of(fp, rd_pos);
  end

  always_comb begin
    we    = 1'b0;
    waddr = slot_of(fp, count);
    wdata = word_in;
    if (s_accept && !full && in_mode == OP_PUSH_BACK) begin
      we = 1'b1;
    end else if (s_accept && !full && in_mode == OP_PUSH_FRONT) begin
      we    = 1'b1;
      waddr = fp_dec;
    end else if (state == S_SHIFT) begin
      we    = 1'b1;
      waddr = slot_of(fp, pos);
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          if (in_mode == OP_REMOVE) begin
            state_next = is_empty ? S_RDF : S_SCAN;
          end else if (in_mode == OP_POP_FRONT || in_mode == OP_POP_BACK) begin
            state_next = is_empty ? S_RDF : S_POP;
          end else begin
            state_next = S_RDF;
          end
        end
      end
      S_SCAN: begin
        if (rdata == word_r) begin
          state_next = (pos + CW'(1) < count) ? S_SHIFT : S_RDF;
        end else if (!(pos + CW'(1) < count)) begin
          state_next = S_RDF;
        end
      end
      S_SHIFT: begin
        if (!(32'(pos) + 2 < count32)) state_next = S_RDF;
      end
      S_POP:   state_next = S_RDF;
      S_RDF:   state_next = S_RDL;
      S_RDL:   state_next = S_OUT;
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fp        <= '0;
      count     <= '0;
      pos       <= '0;
      cap       <= CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) cap <= cfg_data;

      case (state)
        S_IDLE: begin
          if (s_accept) begin
            pos <= '0;
            if ((in_mode == OP_PUSH_BACK || in_mode == OP_PUSH_FRONT) && !full) begin
              count <= count + CW'(1);
              if (in_mode == OP_PUSH_FRONT) fp <= fp_dec;
            end
          end
        end
        S_SCAN: begin
          if (rdata == word_r) begin
            if (!(pos + CW'(1) < count)) count <= count - CW'(1);
          end else if (pos + CW'(1) < count) begin
            pos <= pos + CW'(1);
          end
        end
        S_SHIFT: begin
          if (32'(pos) + 2 < count32) pos <= pos + CW'(1);
          else count <= count - CW'(1);
        end
        S_POP: begin
          count <= count - CW'(1);
          if (mode_r == OP_POP_FRONT) fp <= fp_inc;
        end
        S_RDF: begin
          if (is_empty) fp <= '0;
        end
        default: ;
      endcase

      if (out_load) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      mode_r   <= in_mode;
      word_r   <= word_in;
      popped_r <= '0;
      case (in_mode)
        OP_PUSH_BACK,
        OP_PUSH_FRONT: status_r <= full ? ST_FULL : ST_OK;
        OP_REMOVE:     status_r <= ST_NOMATCH;
        OP_POP_FRONT,
        OP_POP_BACK:   status_r <= is_empty ? ST_EMPTY : ST_OK;
        default:       status_r <= ST_OK;
      endcase
    end
    if (state == S_SCAN && rdata == word_r) status_r <= ST_OK;
    if (state == S_POP) popped_r <= rdata;
    if (state == S_RDL) first_r <= rdata;
    if (out_load) begin
      out_data <= {1'b0,
                   is_empty ? '0 : to_val(rdata),
                   is_empty ? '0 : to_val(first_r),
                   count32[COUNT_W-1:0],
                   to_val(popped_r),
                   status_r};
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= DEPTH)
    else $error("entry count above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_tready)
    else $error("operation accepted while one is in flight");

  a_empty_front: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && is_empty |-> fp == '0)
    else $error("front pointer not parked on empty list");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    s_accept && !full && (in_mode == OP_PUSH_BACK || in_mode == OP_PUSH_FRONT)
    |=> count == $past(count) + CW'(1))
    else $error("push did not grow the list");
`endif

endmodule

FILE: tb/bounded_list_deque_with_match_remove_test.sv
// Self-checking testbench for the bounded list deque with remove-first-match.
// Depends on bldq_pkg and the bounded_list_deque_with_match_remove block.
module bounded_list_deque_with_match_remove_test;
  import bldq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  // Modes 5 to 7 carry no operation
  localparam logic [MODE_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [MODE_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  popped;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  first;
    logic [VALUE_W-1:0]  last;
  } deque_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // mode[2:0], value[34:3]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // status, popped_value, entry_count, first, last
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CAP_W-1:0]     cfg_data = '0;  // capacity_limit

  // Predictor state: list contents front to back and the limit register
  logic [VALUE_W-1:0] deque_words[$];
  logic [CAP_W-1:0]   limit_model = CAP_RESET;
  deque_result_t      pending_results[$];
  logic [VALUE_W-1:0] word_pool[8];

  bit idle_on = 1'b0;
  int fail_count = 0;
  int ops_sent = 0;
  int results_seen = 0;
  int status_hits[4];
  int peak_count = 0;

  bounded_list_deque_with_match_remove dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Apply one operation to the list copy and queue the result it must give
  function automatic void predict_deque_op(input logic [MODE_W-1:0] op,
                                           input logic [VALUE_W-1:0] word);
    deque_result_t res;
    int eff_limit;
    int hit;
    eff_limit = (limit_model > DEPTH) ? DEPTH : int'(limit_model);
    res.status = ST_OK;
    res.popped = '0;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (deque_words.size() >= eff_limit) begin
          res.status = ST_FULL;
        end else if (op == OP_PUSH_BACK) begin
          deque_words.push_back(word);
        end else begin
          deque_words.push_front(word);
        end
      end
      OP_REMOVE: begin
        hit = -1;
        foreach (deque_words[i]) begin
          if (hit < 0 && deque_words[i] == word) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_NOMATCH;
        end else begin
          deque_words.delete(hit);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (deque_words.size() == 0) begin
          res.status = ST_EMPTY;
        end else if (op == OP_POP_FRONT) begin
          res.popped = deque_words.pop_front();
        end else begin
          res.popped = deque_words.pop_back();
        end
      end
      default: ;
    endcase
    res.count = COUNT_W'(deque_words.size());
    res.first = (deque_words.size() != 0) ? deque_words[0] : '0;
    res.last  = (deque_words.size() != 0) ? deque_words[$] : '0;
    if (deque_words.size() > peak_count) peak_count = deque_words.size();
    status_hits[res.status]++;
    pending_results.push_back(res);
  endfunction

  // Send one operation beat; an optional idle burst comes first
  task automatic send_op(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] word);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - MODE_W - VALUE_W){1'b0}}, word, op};
    do @(posedge clk); while (!s_tready);
    predict_deque_op(op, word);
    ops_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CAP_W-1:0] lim);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_model = lim;
  endtask

  task automatic check_field(input string name, input logic [VALUE_W-1:0] exp_v,
                             input logic [VALUE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    deque_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, m_tdata);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", VALUE_W'(exp_r.status), VALUE_W'(m_tdata[1:0]));
        check_field("popped_value", exp_r.popped, m_tdata[33:2]);
        check_field("entry_count", VALUE_W'(exp_r.count), VALUE_W'(m_tdata[38:34]));
        check_field("first_value", exp_r.first, m_tdata[70:39]);
        check_field("last_value", exp_r.last, m_tdata[102:71]);
      end
    end
  end

  // Result-side backpressure
  always begin
    @(posedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    m_tready <= 1'b1;
  end

  function automatic logic [MODE_W-1:0] pick_mode(input int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return OP_RSVD5 + MODE_W'($urandom_range(0, 2));
    if (r < 4 + push_pct) return ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (r < 22 + push_pct) return OP_REMOVE;
    return ($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK;
  endfunction

  // Reuse a small pool so that duplicates and matches are common
  function automatic logic [VALUE_W-1:0] pick_word(input logic [MODE_W-1:0] op);
    if (op == OP_REMOVE && deque_words.size() != 0 && $urandom_range(0, 9) < 7)
      return deque_words[$urandom_range(0, deque_words.size() - 1)];
    if ($urandom_range(0, 1) != 0) return word_pool[$urandom_range(0, 7)];
    return VALUE_W'($urandom);
  endfunction

  task automatic test_edge_ops();
    write_limit(5'd16);
    idle_on = 1'b1;
    send_op(OP_POP_FRONT, 32'h0);
    send_op(OP_POP_BACK, 32'hFFFF_FFFF);
    send_op(OP_REMOVE, 32'h0);
    send_op(OP_RSVD5, 32'hA5A5_A5A5);
    send_op(OP_PUSH_FRONT, 32'h1234_5678);   // front wraps below index zero
    send_op(OP_PUSH_BACK, 32'h0);
    send_op(OP_PUSH_BACK, 32'hFFFF_FFFF);
    send_op(OP_PUSH_BACK, 32'h8000_0000);
    send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_op(OP_PUSH_BACK, 32'h0000_0001);
    send_op(OP_REMOVE, 32'hFFFF_FFFF);       // first of two copies goes
    send_op(OP_REMOVE, 32'hDEAD_BEEF);
    send_op(OP_REMOVE, 32'h0000_0001);       // back entry
    send_op(OP_REMOVE, 32'h0);               // middle entry, gap closes
    send_op(OP_RSVD6, 32'h5A5A_5A5A);
    send_op(OP_RSVD7, 32'h0);
    send_op(OP_POP_FRONT, 32'h0);
    send_op(OP_POP_BACK, 32'h0);
    send_op(OP_POP_FRONT, 32'h0);
    send_op(OP_POP_BACK, 32'h0);
    send_op(OP_REMOVE, 32'hFFFF_FFFF);
  endtask

  task automatic test_capacity_limits();
    // Zero limit refuses every push
    write_limit(5'd0);
    send_op(OP_PUSH_BACK, 32'h1111_1111);
    send_op(OP_PUSH_FRONT, 32'h2222_2222);
    write_limit(5'd1);
    send_op(OP_PUSH_BACK, 32'h3333_3333);
    send_op(OP_PUSH_BACK, 32'h4444_4444);
    send_op(OP_PUSH_FRONT, 32'h5555_5555);
    send_op(OP_POP_BACK, 32'h0);
    // Limit above the storage depth saturates at the depth
    write_limit(5'd31);
    for (int k = 0; k < DEPTH; k++) begin
      if (k % 3 == 0) begin
        send_op(OP_PUSH_FRONT, VALUE_W'($urandom));
      end else begin
        send_op(OP_PUSH_BACK, VALUE_W'($urandom));
      end
    end
    send_op(OP_PUSH_BACK, 32'hFFFF_FFFF);
    send_op(OP_PUSH_FRONT, 32'h0);
    send_op(OP_REMOVE, deque_words[DEPTH / 2]);
    // Limit dropped below the count keeps the entries, refuses pushes
    write_limit(5'd3);
    send_op(OP_PUSH_BACK, 32'h6666_6666);
    while (deque_words.size() > 2) begin
      send_op(($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK, 32'h0);
    end
    send_op(OP_PUSH_BACK, 32'h7777_7777);
    send_op(OP_PUSH_FRONT, 32'h8888_8888);
    while (deque_words.size() > 0) send_op(OP_POP_FRONT, 32'h0);
  endtask

  task automatic test_random_traffic(input logic [CAP_W-1:0] lim, input int n_items,
                                     input bit with_idle);
    logic [MODE_W-1:0] op;
    int push_pct;
    write_limit(lim);
    idle_on = with_idle;
    for (int k = 0; k < n_items; k++) begin
      // Alternate fill and drain stretches so the list swings between ends
      push_pct = ((k / 24) % 2 == 0) ? 60 : 25;
      op = pick_mode(push_pct);
      send_op(op, pick_word(op));
    end
  endtask

  initial begin
    word_pool[0] = '0;
    word_pool[1] = '1;
    for (int k = 2; k < 8; k++) word_pool[k] = VALUE_W'($urandom);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_edge_ops();
    test_capacity_limits();
    test_random_traffic(5'd16, 180, 1'b1);
    test_random_traffic(5'd31, 110, 1'b1);
    test_random_traffic(5'd4, 90, 1'b1);
    test_random_traffic(5'd1, 60, 1'b1);
    test_random_traffic(5'd0, 30, 1'b1);
    test_random_traffic(5'd9, 110, 1'b1);
    test_random_traffic(5'd16, 110, 1'b0);
    wait_idle();
    repeat (40) @(posedge clk);
    $display("Ran %0d operations, %0d results checked, peak list size %0d.",
             ops_sent, results_seen, peak_count);
    $display("Status mix: ok %0d, full refused %0d, empty refused %0d, no match %0d.",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_NOMATCH]);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
